[hdl/srm_pkg.sv]
// Shared types, codes and constants of the sensor running-average monitor.
package srm_pkg;

    localparam int WINDOW_DEF      = 5;
    localparam int MAX_SENSORS_DEF = 64;

    localparam logic signed [15:0] MAX_TEMP_RST = 16'sd7680;
    localparam logic signed [15:0] MIN_TEMP_RST = 16'sd2560;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_MEAS  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic {
        CFG_MAX_TEMP = 1'b0,
        CFG_MIN_TEMP = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_LOAD,
        RES_FULL,
        RES_UNK,
        RES_HIT
    } t_res;

    typedef struct packed {
        logic latch;
        logic load_wr;
        logic idx_init;
        logic idx_dec;
        logic sensor_rd;
        logic meta_rd;
        logic meta_cap;
        logic upd;
        logic ring_rd;
        logic sum_acc;
        logic div_start;
        logic div_step;
        logic avg_wr;
        logic out_load;
        t_res kind;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic in_valid;
        logic full;
        logic empty;
        logic match;
        logic idx_zero;
        logic k_last;
        logic fill_next_full;
        logic out_busy;
    } t_dp_sts;

endpackage

[hdl/srm_in_if.sv]
// Input word channel: command and sensor payload with valid/ready.
interface srm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [15:0]        sensor_key;
    logic [15:0]        room_number;
    logic signed [15:0] temperature;
    logic [31:0]        timestamp;

    modport source (output valid, command, sensor_key, room_number, temperature, timestamp,
                    input ready);
    modport sink   (input valid, command, sensor_key, room_number, temperature, timestamp,
                    output ready);
endinterface

[hdl/srm_out_if.sv]
// Result word channel with valid/ready.
interface srm_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [15:0]        room_out;
    logic signed [15:0] average;
    logic               average_valid;
    logic               too_hot;
    logic               too_cold;
    logic [31:0]        last_time;
    logic [6:0]         sensor_total;

    modport source (output valid, status, room_out, average, average_valid, too_hot,
                    too_cold, last_time, sensor_total, input ready);
    modport sink   (input valid, status, room_out, average, average_valid, too_hot,
                    too_cold, last_time, sensor_total, output ready);
endinterface

[hdl/srm_cfg_if.sv]
// Configuration write channel: register index and data with valid/ready.
interface srm_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/srm_dp.sv]
// Datapath: table memories, reading rings, summing, divider and result register.
module srm_dp #(
    parameter int WINDOW      = srm_pkg::WINDOW_DEF,
    parameter int MAX_SENSORS = srm_pkg::MAX_SENSORS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  srm_pkg::t_dp_cmd i_cmd,
    output srm_pkg::t_dp_sts o_sts,
    srm_in_if.sink           i_in,
    srm_out_if.source        o_out,
    srm_cfg_if.sink          i_cfg
);
    localparam int IW     = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int CW     = $clog2(MAX_SENSORS + 1);
    localparam int RD     = MAX_SENSORS * WINDOW;
    localparam int RAW    = (RD > 1) ? $clog2(RD) : 1;
    localparam int PW     = $clog2(WINDOW + 1);
    localparam int KW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = 16 + $clog2(WINDOW + 1);
    localparam int MAG_W  = SUM_W - 1;
    // divide by WINDOW as multiply by a rounded-up reciprocal, exact for MAG_W-bit magnitudes
    localparam int SH     = MAG_W + $clog2(WINDOW);
    localparam int RCW    = SH + 1;
    localparam int PRW    = MAG_W + RCW;
    localparam logic [RCW-1:0] RECIP =
        RCW'(((64'd1 << SH) + 64'(WINDOW - 1)) / 64'(WINDOW));

    // memories
    logic [15:0]        m_sensor [MAX_SENSORS];
    logic [15:0]        m_room   [MAX_SENSORS];
    logic [PW-1:0]      m_fill   [MAX_SENSORS];
    logic [PW-1:0]      m_pos    [MAX_SENSORS];
    logic signed [15:0] m_avg    [MAX_SENSORS];
    logic [31:0]        m_time   [MAX_SENSORS];
    logic signed [15:0] m_ring   [RD];

    logic [15:0]        r_sensor_q, r_room_q;
    logic [PW-1:0]      r_fill_q, r_pos_q;
    logic signed [15:0] r_avg_q, r_ring_q;
    logic [31:0]        r_time_q;

    // latched item
    srm_pkg::t_cmd      r_cmd;
    logic [15:0]        r_id, r_room_in;
    logic signed [15:0] r_temp;
    logic [31:0]        r_ts;

    logic signed [15:0] r_max, r_min;
    logic [CW-1:0]      r_count, r_total;
    logic [IW-1:0]      r_idx;
    logic [RAW-1:0]     r_base;
    logic [KW-1:0]      r_k;

    // working copy of the found entry
    logic [15:0]        r_room;
    logic [PW-1:0]      r_fill, r_pos;
    logic signed [15:0] r_avg;
    logic [31:0]        r_time;
    logic               r_hot, r_cold;

    logic signed [SUM_W-1:0] r_sum;
    logic [MAG_W-1:0]   r_dq;
    logic [PRW-1:0]     r_prod;
    logic               r_neg;

    logic               r_out_valid;
    logic [1:0]         r_o_status;
    logic [15:0]        r_o_room;
    logic signed [15:0] r_o_avg;
    logic               r_o_avalid, r_o_hot, r_o_cold;
    logic [31:0]        r_o_time;
    logic [6:0]         r_o_total;

    logic [IW-1:0]      tbl_addr;
    logic [PW-1:0]      pos_cur, pos_nxt, fill_nxt;
    logic [RAW-1:0]     ring_addr;
    logic [15:0]        quot;
    logic signed [15:0] avg_new;
    logic               valid_now;

    assign tbl_addr  = i_cmd.load_wr ? r_count[IW-1:0] : r_idx;
    assign pos_cur   = (r_pos >= PW'(WINDOW)) ? '0 : r_pos;
    assign pos_nxt   = (pos_cur + PW'(1) >= PW'(WINDOW)) ? '0 : pos_cur + PW'(1);
    assign fill_nxt  = (r_fill < PW'(WINDOW)) ? r_fill + PW'(1) : r_fill;
    assign ring_addr = i_cmd.upd ? RAW'(r_base + RAW'(pos_cur)) : RAW'(r_base + RAW'(r_k));
    assign quot      = r_prod[SH +: 16];
    assign avg_new   = r_neg ? -$signed(quot) : $signed(quot);
    assign valid_now = r_fill >= PW'(WINDOW);

    always_comb begin
        o_sts.cmd            = r_cmd;
        o_sts.in_valid       = i_in.valid;
        o_sts.full           = r_count == CW'(MAX_SENSORS);
        o_sts.empty          = r_count == '0;
        o_sts.match          = r_sensor_q == r_id;
        o_sts.idx_zero       = r_idx == '0;
        o_sts.k_last         = r_k == KW'(WINDOW - 1);
        o_sts.fill_next_full = fill_nxt >= PW'(WINDOW);
        o_sts.out_busy       = r_out_valid && !o_out.ready;
    end

    assign i_in.ready  = i_cmd.latch;
    assign i_cfg.ready = 1'b1;

    // table memories, one port each
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            m_sensor[tbl_addr] <= r_id;
            m_room[tbl_addr]   <= r_room_in;
        end
        if (i_cmd.sensor_rd) begin
            r_sensor_q <= m_sensor[tbl_addr];
        end
        if (i_cmd.meta_rd) begin
            r_room_q <= m_room[tbl_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr || i_cmd.upd) begin
            m_fill[tbl_addr] <= i_cmd.load_wr ? '0 : fill_nxt;
            m_pos[tbl_addr]  <= i_cmd.load_wr ? '0 : pos_nxt;
            m_time[tbl_addr] <= i_cmd.load_wr ? '0 : r_ts;
        end
        if (i_cmd.meta_rd) begin
            r_fill_q <= m_fill[tbl_addr];
            r_pos_q  <= m_pos[tbl_addr];
            r_time_q <= m_time[tbl_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr || i_cmd.avg_wr) begin
            m_avg[tbl_addr] <= i_cmd.load_wr ? '0 : avg_new;
        end
        if (i_cmd.meta_rd) begin
            r_avg_q <= m_avg[tbl_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            m_ring[ring_addr] <= r_temp;
        end
        if (i_cmd.ring_rd) begin
            r_ring_q <= m_ring[ring_addr];
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch && i_in.valid) begin
            r_cmd     <= srm_pkg::t_cmd'(i_in.command);
            r_id      <= i_in.sensor_key;
            r_room_in <= i_in.room_number;
            r_temp    <= i_in.temperature;
            r_ts      <= i_in.timestamp;
        end
        if (i_cmd.idx_init) begin
            r_idx <= IW'(r_count - CW'(1));
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - IW'(1);
        end
        if (i_cmd.meta_rd) begin
            r_base <= RAW'(r_idx * WINDOW);
        end
        if (i_cmd.meta_cap) begin
            r_room <= r_room_q;
            r_fill <= r_fill_q;
            r_pos  <= r_pos_q;
            r_avg  <= r_avg_q;
            r_time <= r_time_q;
            r_hot  <= 1'b0;
            r_cold <= 1'b0;
        end
        if (i_cmd.upd) begin
            r_fill <= fill_nxt;
            r_time <= r_ts;
            r_k    <= '0;
            r_sum  <= '0;
        end
        if (i_cmd.sum_acc) begin
            r_sum <= r_sum + SUM_W'(r_ring_q);
            r_k   <= r_k + KW'(1);
        end
        if (i_cmd.div_start) begin
            r_neg <= r_sum[SUM_W-1];
            r_dq  <= MAG_W'(r_sum[SUM_W-1] ? -r_sum : r_sum);
        end
        if (i_cmd.div_step) begin
            r_prod <= r_dq * RECIP;
        end
        if (i_cmd.avg_wr) begin
            r_avg  <= avg_new;
            r_hot  <= avg_new > r_max;
            r_cold <= avg_new < r_min;
        end
    end

    // control registers: table count, nonzero-id total, thresholds, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_total     <= '0;
            r_max       <= srm_pkg::MAX_TEMP_RST;
            r_min       <= srm_pkg::MIN_TEMP_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_wr) begin
                r_count <= r_count + CW'(1);
                if (r_id != '0) begin
                    r_total <= r_total + CW'(1);
                end
            end
            if (i_cfg.valid) begin
                unique case (srm_pkg::t_cfg_idx'(i_cfg.index))
                    srm_pkg::CFG_MAX_TEMP: r_max <= i_cfg.data;
                    srm_pkg::CFG_MIN_TEMP: r_min <= i_cfg.data;
                    default:               r_max <= r_max;
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status <= srm_pkg::ST_OK;
            r_o_room   <= '0;
            r_o_avg    <= '0;
            r_o_avalid <= 1'b0;
            r_o_hot    <= 1'b0;
            r_o_cold   <= 1'b0;
            r_o_time   <= '0;
            r_o_total  <= 7'(r_total);
            unique case (i_cmd.kind)
                srm_pkg::RES_LOAD: r_o_room   <= r_room_in;
                srm_pkg::RES_FULL: r_o_status <= srm_pkg::ST_FULL;
                srm_pkg::RES_UNK:  r_o_status <= srm_pkg::ST_UNKNOWN;
                srm_pkg::RES_HIT: begin
                    r_o_room   <= r_room;
                    r_o_avg    <= valid_now ? r_avg : '0;
                    r_o_avalid <= valid_now;
                    r_o_hot    <= r_hot;
                    r_o_cold   <= r_cold;
                    r_o_time   <= r_time;
                end
                default: r_o_status <= srm_pkg::ST_OK;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_o_status;
    assign o_out.room_out      = r_o_room;
    assign o_out.average       = r_o_avg;
    assign o_out.average_valid = r_o_avalid;
    assign o_out.too_hot       = r_o_hot;
    assign o_out.too_cold      = r_o_cold;
    assign o_out.last_time     = r_o_time;
    assign o_out.sensor_total  = r_o_total;

endmodule

[hdl/srm_ctrl.sv]
// Controller: sequences load, search, ring update, summing and division.
module srm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  srm_pkg::t_dp_sts i_sts,
    output srm_pkg::t_dp_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_SADDR, S_SCMP, S_MRD, S_MCAP, S_UPD,
        S_RADDR, S_RACC, S_DIVS, S_DIV, S_AVW, S_FIN
    } t_state;

    t_state        r_state, n_state;
    srm_pkg::t_res r_kind, n_kind;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.kind = r_kind;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_FIN;
                unique case (i_sts.cmd)
                    srm_pkg::CMD_LOAD: begin
                        if (i_sts.full) begin
                            n_kind = srm_pkg::RES_FULL;
                        end else begin
                            o_cmd.load_wr = 1'b1;
                            n_kind = srm_pkg::RES_LOAD;
                        end
                    end
                    srm_pkg::CMD_MEAS, srm_pkg::CMD_QUERY: begin
                        if (i_sts.empty) begin
                            n_kind = srm_pkg::RES_UNK;
                        end else begin
                            o_cmd.idx_init = 1'b1;
                            n_state = S_SADDR;
                        end
                    end
                    default: n_kind = srm_pkg::RES_NONE;
                endcase
            end
            S_SADDR: begin
                o_cmd.sensor_rd = 1'b1;
                n_state = S_SCMP;
            end
            S_SCMP: begin
                priority if (i_sts.match) begin
                    n_state = S_MRD;
                end else if (i_sts.idx_zero) begin
                    n_kind  = srm_pkg::RES_UNK;
                    n_state = S_FIN;
                end else begin
                    o_cmd.idx_dec = 1'b1;
                    n_state = S_SADDR;
                end
            end
            S_MRD: begin
                o_cmd.meta_rd = 1'b1;
                n_state = S_MCAP;
            end
            S_MCAP: begin
                o_cmd.meta_cap = 1'b1;
                n_kind = srm_pkg::RES_HIT;
                n_state = (i_sts.cmd == srm_pkg::CMD_MEAS) ? S_UPD : S_FIN;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = i_sts.fill_next_full ? S_RADDR : S_FIN;
            end
            S_RADDR: begin
                o_cmd.ring_rd = 1'b1;
                n_state = S_RACC;
            end
            S_RACC: begin
                o_cmd.sum_acc = 1'b1;
                n_state = i_sts.k_last ? S_DIVS : S_RADDR;
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state = S_AVW;
            end
            S_AVW: begin
                o_cmd.avg_wr = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and result kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= srm_pkg::RES_NONE;
        end else begin
            r_kind  <= n_kind;
            r_state <= n_state;
        end
    end

endmodule

[hdl/sensor_running_average_monitor_unit.sv]
// Sensor running-average monitor: id-to-room table with per-sensor averaging rings.
// A load, a full table, an empty table or command 3 go straight to the result; a search reads
// entries from the newest down, a hit then reads the entry, a measurement writes its ring,
// and one whose window is then full also sums the ring and divides before the result loads.
// Throughput: one word at a time, next one taken in the cycle after its result loads; a result
// held by the sink stalls the following one. Reset (synchronous, active low): empty table,
// thresholds 30.0 and 10.0, no result; no clearing pass, entries are cleared when loaded.
module sensor_running_average_monitor_unit #(
    parameter int WINDOW      = srm_pkg::WINDOW_DEF,
    parameter int MAX_SENSORS = srm_pkg::MAX_SENSORS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srm_in_if.sink    i_in,
    srm_out_if.source o_out,
    srm_cfg_if.sink   i_cfg
);
    srm_pkg::t_dp_cmd cmd;
    srm_pkg::t_dp_sts sts;

    // In idle the controller offers ready and moves on once a word is present.
    srm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    srm_dp #(
        .WINDOW      (WINDOW),
        .MAX_SENSORS (MAX_SENSORS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg)
    );

endmodule
